@@ design/mvm_pkg.sv @@
// Shared constants and types for the matrix-vector multiply block.
package mvm_pkg;

  localparam int COLUMNS_MAX_DEF = 1024;
  localparam int ROWS_MAX_DEF    = 1024;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;
  localparam int CFG_W   = 11;
  localparam int SUM_W   = 64;
  localparam int ROW_W   = 10;
  localparam int WIDE_W  = 17;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [CFG_W-1:0] COLS_RESET = 11'd1024;

  localparam logic        KIND_VECTOR = 1'b0;
  localparam logic        KIND_MATRIX = 1'b1;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [SUM_W-1:0] row_sum;
    logic [ROW_W-1:0] row_number;
    logic             overflow;
  } res_word_t;

endpackage

@@ design/mvm_fifo.sv @@
// Small first-in first-out queue built from flip-flops.
module mvm_fifo import mvm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = MID_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/mvm_front.sv @@
// Front end: accepts words, tracks the column and tags the last element of each row.
module mvm_front import mvm_pkg::*; #(
  parameter int COLUMNS_MAX = COLUMNS_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      q_full,
  input  logic                      kind,
  input  logic signed [VALUE_W-1:0] element_value,
  input  logic [INDEX_W-1:0]        vector_index,
  input  logic [CFG_W-1:0]          columns_in_use,
  output logic                      q_push,
  output logic [$clog2(COLUMNS_MAX)+VALUE_W+1:0] q_data
);

  localparam int CW = $clog2(COLUMNS_MAX);

  logic [CW-1:0]     col;
  logic [CW-1:0]     col_next;
  logic [WIDE_W-1:0] cfg_wide;
  logic [WIDE_W-1:0] eff;
  logic [WIDE_W-1:0] col_plus;
  logic [WIDE_W-1:0] idx_wide;
  logic              accept;
  logic              last;
  logic              idx_ok;
  logic [CW-1:0]     addr;

  assign accept   = push && !q_full;
  assign cfg_wide = WIDE_W'(columns_in_use);
  assign idx_wide = WIDE_W'(vector_index);
  assign idx_ok   = idx_wide < WIDE_W'(COLUMNS_MAX);
  assign col_plus = WIDE_W'(col) + 1'b1;

  always_comb begin
    if (columns_in_use == '0) begin
      eff = WIDE_W'(1);
    end else if (cfg_wide > WIDE_W'(COLUMNS_MAX)) begin
      eff = WIDE_W'(COLUMNS_MAX);
    end else begin
      eff = cfg_wide;
    end
  end

  assign last     = (col_plus >= eff);
  assign col_next = last ? '0 : col_plus[CW-1:0];
  assign addr     = (kind == KIND_VECTOR) ? idx_wide[CW-1:0] : col;

  // entry: {is_load, last, addr, value}
  assign q_push = accept && ((kind == KIND_MATRIX) || idx_ok);
  assign q_data = {(kind == KIND_VECTOR), last, addr, element_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (accept && (kind == KIND_MATRIX)) begin
      col <= col_next;
    end
  end

endmodule

@@ design/mvm_back.sv @@
// Back end: vector store, multiplier and saturating row accumulator.
module mvm_back import mvm_pkg::*; #(
  parameter int COLUMNS_MAX = COLUMNS_MAX_DEF,
  parameter int ROWS_MAX    = ROWS_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_empty,
  input  logic [$clog2(COLUMNS_MAX)+VALUE_W+1:0] q_data,
  output logic                                   q_pop,
  input  logic                                   out_full,
  output logic                                   res_push,
  output res_word_t                              res_word
);

  localparam int CW = $clog2(COLUMNS_MAX);
  localparam int RW = $clog2(ROWS_MAX);

  logic [VALUE_W-1:0] store [COLUMNS_MAX];

  logic                      e_load;
  logic                      e_last;
  logic [CW-1:0]             e_addr;
  logic [VALUE_W-1:0]        e_value;
  logic                      adv;

  logic                      s1_valid;
  logic                      s1_last;
  logic signed [VALUE_W-1:0] s1_a;
  logic signed [VALUE_W-1:0] s1_b;

  logic                      s2_valid;
  logic                      s2_last;
  logic [SUM_W-1:0]          s2_prod;

  logic [SUM_W-1:0]          acc;
  logic                      sat_flag;
  logic [RW-1:0]             row;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          sum_sat;
  logic                      ovf;
  logic [WIDE_W-1:0]         row_wide;

  assign {e_load, e_last, e_addr, e_value} = q_data;

  assign adv   = !(s2_valid && s2_last && out_full);
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop && e_load) begin
      store[e_addr] <= e_value;
    end
    if (q_pop && !e_load) begin
      s1_b <= store[e_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a    <= e_value;
      s1_last <= e_last;
      s2_prod <= SUM_W'(s1_a) * SUM_W'(s1_b);
      s2_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_pop && !e_load;
      s2_valid <= s1_valid;
    end
  end

  assign sum     = acc + s2_prod;
  assign ovf     = (acc[SUM_W-1] == s2_prod[SUM_W-1]) && (sum[SUM_W-1] != acc[SUM_W-1]);
  assign sum_sat = ovf ? (acc[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum;

  assign row_wide = WIDE_W'(row);
  assign res_push = adv && s2_valid && s2_last;
  assign res_word = '{row_sum: sum_sat, row_number: row_wide[ROW_W-1:0],
                      overflow: sat_flag || ovf};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      sat_flag <= 1'b0;
      row      <= '0;
    end else if (adv && s2_valid) begin
      if (s2_last) begin
        acc      <= '0;
        sat_flag <= 1'b0;
        row      <= (row_wide == WIDE_W'(ROWS_MAX - 1)) ? '0 : row + 1'b1;
      end else begin
        acc      <= sum_sat;
        sat_flag <= sat_flag || ovf;
      end
    end
  end

endmodule

@@ design/matrix_vector_multiply.sv @@
// Matrix-vector multiply top level: queues, front end, back end and width register.
// Takes one word per clock, vector loads and matrix elements alike, and sustains that rate
// while the result queue has room. A matrix element passes the input queue, a vector store
// read (one port of a COLUMNS_MAX-word memory, shared with the loads), a 32x32 multiplier
// and a 64-bit saturating adder; after the operand and product registers, a row sum is written
// to the result queue, from which it shows on the result ports. A load is written to the store
// in queue order, so a matrix element pushed after a load of its column sees the new value.
module matrix_vector_multiply import mvm_pkg::*; #(
  parameter int COLUMNS_MAX = COLUMNS_MAX_DEF,
  parameter int ROWS_MAX    = ROWS_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      kind,
  input  logic signed [VALUE_W-1:0] element_value,
  input  logic [INDEX_W-1:0]        vector_index,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [SUM_W-1:0]   row_sum,
  output logic [ROW_W-1:0]          row_number,
  output logic                      overflow,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int CW = $clog2(COLUMNS_MAX);
  localparam int MW = CW + VALUE_W + 2;

  logic [CFG_W-1:0] columns_in_use;
  logic             q_push;
  logic [MW-1:0]    q_in;
  logic             q_full;
  logic             q_pop;
  logic [MW-1:0]    q_out;
  logic             q_empty;
  logic             res_push;
  res_word_t        res_word;
  res_word_t        out_word;
  logic             out_full;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      columns_in_use <= cfg_data;
    end
  end

  mvm_front #(.COLUMNS_MAX(COLUMNS_MAX)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .q_full        (q_full),
    .kind          (kind),
    .element_value (element_value),
    .vector_index  (vector_index),
    .columns_in_use(columns_in_use),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  mvm_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_out),
    .empty(q_empty)
  );

  mvm_back #(.COLUMNS_MAX(COLUMNS_MAX), .ROWS_MAX(ROWS_MAX)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_full(out_full),
    .res_push(res_push),
    .res_word(res_word)
  );

  mvm_fifo #(.WIDTH($bits(res_word_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_word),
    .full (out_full),
    .pop  (pop),
    .dout (out_word),
    .empty(empty)
  );

  assign row_sum    = out_word.row_sum;
  assign row_number = out_word.row_number;
  assign overflow   = out_word.overflow;

endmodule

@@ design/mvm_checker.sv @@
// Port-level checks for the matrix-vector multiply block, bound to the top level.
module mvm_checker import mvm_pkg::*; #(
  parameter int ROWS_MAX = ROWS_MAX_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      push,
  input logic                      full,
  input logic                      kind,
  input logic                      empty,
  input logic                      pop,
  input logic signed [SUM_W-1:0]   row_sum,
  input logic [ROW_W-1:0]          row_number,
  input logic                      overflow,
  input logic                      cfg_ready
);

  logic [WIDE_W-1:0] last_row;
  logic              have_last;
  logic [WIDE_W-1:0] row_expect;
  logic              taken;

  assign taken      = pop && !empty;
  assign row_expect = (last_row == WIDE_W'(ROWS_MAX - 1)) ? '0 : last_row + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
      last_row  <= '0;
    end else if (taken) begin
      have_last <= 1'b1;
      last_row  <= WIDE_W'(row_number);
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(row_sum) && $stable(row_number)
                          && $stable(overflow)))
    else $error("waiting result word changed");

  a_row_sequence: assert property (@(posedge clk) disable iff (rst)
    (taken && have_last) |-> (row_number == row_expect[ROW_W-1:0]))
    else $error("row numbers out of sequence");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !kind) |=> !$fell(cfg_ready))
    else $error("config port dropped ready");

endmodule

bind matrix_vector_multiply mvm_checker #(.ROWS_MAX(ROWS_MAX)) u_mvm_checker (.*);

@@ tb/matrix_vector_multiply_test.sv @@
// Self-checking testbench for the fixed-point matrix-vector multiply block.
module matrix_vector_multiply_test;
  import mvm_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic kind = KIND_VECTOR;
  logic signed [VALUE_W-1:0] element_value = '0;
  logic [INDEX_W-1:0] vector_index = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SUM_W-1:0] row_sum;
  logic [ROW_W-1:0] row_number;
  logic overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // predicted block state
  logic [VALUE_W-1:0] vec_store [COLUMNS_MAX_DEF];
  bit loaded [COLUMNS_MAX_DEF];
  logic signed [SUM_W-1:0] acc = '0;
  bit sat = 1'b0;
  int col_cnt = 0;
  int row_cnt = 0;
  logic [CFG_W-1:0] width_reg = COLS_RESET;

  res_word_t pending_rows [$];
  int mismatches = 0;
  int stall_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;

  matrix_vector_multiply i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .kind(kind),
    .element_value(element_value),
    .vector_index(vector_index),
    .empty(empty),
    .pop(pop),
    .row_sum(row_sum),
    .row_number(row_number),
    .overflow(overflow),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > COLUMNS_MAX_DEF) return COLUMNS_MAX_DEF;
    return int'(width_reg);
  endfunction

  function automatic void predict_word(logic k, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] i);
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] b;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;
    res_word_t r;
    if (k == KIND_VECTOR) begin
      vec_store[i] = v;
      loaded[i] = 1'b1;
      return;
    end
    a = {{32{v[31]}}, v};
    b = {{32{vec_store[col_cnt][31]}}, vec_store[col_cnt]};
    prod = a * b;
    sum = acc + prod;
    if (acc[63] == prod[63] && sum[63] != acc[63]) begin
      sum = acc[63] ? SUM_MIN : SUM_MAX;
      sat = 1'b1;
    end
    acc = sum;
    if (col_cnt + 1 >= eff_width()) begin
      r.row_sum = acc;
      r.row_number = row_cnt[ROW_W-1:0];
      r.overflow = sat;
      pending_rows.push_back(r);
      acc = '0;
      sat = 1'b0;
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= ROWS_MAX_DEF) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return $urandom_range(255) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic note_mismatch(string what, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", what, exp_v, act_v);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    res_word_t r;
    if (!rst && pop && !empty) begin
      if (pending_rows.size() == 0) begin
        note_mismatch("unexpected row", '0, row_sum);
      end else begin
        r = pending_rows.pop_front();
        if (r.row_sum !== row_sum) note_mismatch("row_sum", r.row_sum, row_sum);
        if (r.row_number !== row_number) note_mismatch("row_number", r.row_number, row_number);
        if (r.overflow !== overflow) note_mismatch("overflow", r.overflow, overflow);
      end
    end
  end

  // receiver, with an optional hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      pop <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("matrix_vector_multiply_test: done, errors");
        $finish;
      end
    end
  end

  task automatic send_word(logic k, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] i);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    push <= 1'b1;
    kind <= k;
    element_value <= v;
    vector_index <= i;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_word(k, v, i);
  endtask

  // loads the column first if it was never written
  task automatic send_matrix(logic [VALUE_W-1:0] v);
    if (!loaded[col_cnt]) send_word(KIND_VECTOR, rand_value(), col_cnt[INDEX_W-1:0]);
    send_word(KIND_MATRIX, v, INDEX_W'($urandom_range(1023)));
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_W-1:0] w);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = w;
  endtask

  // no row may end early at the reset width; a narrow width then closes it
  task automatic test_reset_width();
    repeat (32) send_matrix(rand_value());
    cfg_write(11'd1);
    send_matrix(rand_value());
  endtask

  task automatic test_directed_cases();
    cfg_write(11'd3);
    send_word(KIND_VECTOR, 32'h8000_0000, 10'd0);
    send_word(KIND_VECTOR, 32'h8000_0000, 10'd1);
    send_word(KIND_VECTOR, 32'h8000_0000, 10'd2);
    send_word(KIND_VECTOR, 32'h5a5a_a5a5, 10'h3ff);
    // positive saturation
    repeat (3) send_word(KIND_MATRIX, 32'h8000_0000, 10'h3ff);
    send_word(KIND_VECTOR, 32'h7fff_ffff, 10'd1);
    send_word(KIND_VECTOR, 32'h7fff_ffff, 10'd2);
    // negative saturation
    send_word(KIND_MATRIX, 32'h7fff_ffff, 10'd0);
    send_word(KIND_MATRIX, 32'h8000_0000, 10'h155);
    send_word(KIND_MATRIX, 32'h8000_0000, 10'h2aa);
    // load into a column still ahead in the row
    send_word(KIND_MATRIX, 32'h0001_0000, 10'd0);
    send_word(KIND_VECTOR, 32'h0002_0000, 10'd1);
    send_word(KIND_MATRIX, 32'hffff_ffff, 10'd0);
    send_word(KIND_MATRIX, 32'h0000_0000, 10'd0);
    // width drops below the column count mid-row
    send_word(KIND_MATRIX, 32'h0000_8000, 10'd0);
    cfg_write(11'd1);
    send_word(KIND_MATRIX, 32'hffff_0000, 10'd0);
    // zero width acts as one
    cfg_write(11'd0);
    send_word(KIND_MATRIX, 32'h1234_5678, 10'd0);
    send_word(KIND_MATRIX, 32'h8000_0000, 10'h3ff);
  endtask

  task automatic test_random_rows(logic [CFG_W-1:0] w, int n);
    cfg_write(w);
    repeat (n) begin
      if ($urandom_range(99) < 15)
        send_word(KIND_VECTOR, rand_value(), INDEX_W'($urandom_range(1023)));
      else send_matrix(rand_value());
    end
  endtask

  task automatic test_backpressure();
    cfg_write(11'd1);
    rx_hold <= 400;
    repeat (120) send_matrix(rand_value());
    wait_drain();
    repeat (30) send_matrix(rand_value());
  endtask

  // an oversized width must not end the row early
  task automatic test_width_clamp();
    cfg_write(11'h7ff);
    repeat (40) send_matrix(rand_value());
    cfg_write(11'd2);
    send_matrix(rand_value());
  endtask

  task automatic test_row_wrap();
    int n;
    cfg_write(11'd1);
    n = ROWS_MAX_DEF - row_cnt + 10;
    repeat (n) send_matrix(rand_value());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 18;
    rx_idle_pct = 85;
    test_reset_width();
    test_directed_cases();
    test_random_rows(11'd1, 100);
    test_random_rows(11'd2, 100);
    test_random_rows(11'd3, 100);

    tx_idle_pct = 85;
    rx_idle_pct = 18;
    test_random_rows(11'd5, 100);
    test_random_rows(11'd0, 100);
    test_random_rows(11'd16, 100);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_width_clamp();
    test_row_wrap();
    test_random_rows(11'd4, 100);
    test_random_rows(11'd2, 50);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0)
      $display("matrix_vector_multiply_test: done, clean");
    else
      $display("matrix_vector_multiply_test: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mvm_pkg.sv
design/mvm_fifo.sv
design/mvm_front.sv
design/mvm_back.sv
design/matrix_vector_multiply.sv
design/mvm_checker.sv
tb/matrix_vector_multiply_test.sv
